[hdl/scta_pkg.sv]
`timescale 1ns / 1ps

package scta_pkg;

    localparam int unsigned C_CHAR_W   = 7;
    localparam int unsigned C_CODE_W   = 8;
    localparam int unsigned C_KIND_W   = 2;
    localparam int unsigned C_MAP_SIZE = 58;

    localparam logic [C_KIND_W-1:0] C_KIND_SCAN  = 2'd0;
    localparam logic [C_KIND_W-1:0] C_KIND_POP   = 2'd1;
    localparam logic [C_KIND_W-1:0] C_KIND_CLEAR = 2'd2;

    localparam logic [C_CODE_W-1:0] C_LSHIFT_MAKE  = 8'h2A;
    localparam logic [C_CODE_W-1:0] C_RSHIFT_MAKE  = 8'h36;
    localparam logic [C_CODE_W-1:0] C_LSHIFT_BREAK = 8'hAA;
    localparam logic [C_CODE_W-1:0] C_RSHIFT_BREAK = 8'hB6;
    localparam logic [C_CODE_W-1:0] C_CAPS_MAKE    = 8'h3A;
    localparam logic [C_CHAR_W-1:0] C_CASE_BIT     = 7'h20;

    localparam logic [C_CHAR_W-1:0] C_MAP_PLAIN [0:C_MAP_SIZE-1] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
        7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    localparam logic [C_CHAR_W-1:0] C_MAP_SHIFT [0:C_MAP_SIZE-1] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
        7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    typedef enum logic [1:0] {
        OP_NONE,
        OP_PUSH,
        OP_POP,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [C_CHAR_W-1:0] ch;
    } t_cmd;

endpackage

[hdl/scta_ram.sv]
`timescale 1ns / 1ps

module scta_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/scta_front.sv]
`timescale 1ns / 1ps

module scta_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [scta_pkg::C_KIND_W-1:0]  i_kind,
    input  logic [scta_pkg::C_CODE_W-1:0]  i_scan_code,
    input  logic                           i_q_full,
    output logic                           o_q_push,
    output scta_pkg::t_cmd                 o_q_cmd
);
    import scta_pkg::*;

    logic                r_shift_held;
    logic                r_caps_on;
    logic                n_shift_held;
    logic                n_caps_on;
    logic                accept;
    logic [C_CHAR_W-1:0] map_char;
    logic [C_CHAR_W-1:0] dec_char;
    logic                is_letter;
    logic [5:0]          map_idx;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_q_push   = accept;

    // Codes above the table are filtered below, so only the low six bits index it.
    assign map_idx = i_scan_code[5:0];

    always_comb begin
        map_char = '0;
        if (i_scan_code < C_CODE_W'(C_MAP_SIZE)) begin
            map_char = r_shift_held ? C_MAP_SHIFT[map_idx] : C_MAP_PLAIN[map_idx];
        end
        is_letter = (map_char >= 7'h61 && map_char <= 7'h7A) ||
                    (map_char >= 7'h41 && map_char <= 7'h5A);
        dec_char  = (r_caps_on && is_letter) ? (map_char ^ C_CASE_BIT) : map_char;
    end

    always_comb begin
        n_shift_held = r_shift_held;
        n_caps_on    = r_caps_on;
        o_q_cmd.op   = OP_NONE;
        o_q_cmd.ch   = dec_char;
        unique case (i_kind)
            C_KIND_SCAN: begin
                if (i_scan_code == C_LSHIFT_MAKE || i_scan_code == C_RSHIFT_MAKE) begin
                    n_shift_held = 1'b1;
                end else if (i_scan_code == C_LSHIFT_BREAK ||
                             i_scan_code == C_RSHIFT_BREAK) begin
                    n_shift_held = 1'b0;
                end else if (i_scan_code == C_CAPS_MAKE) begin
                    n_caps_on = !r_caps_on;
                end else if (dec_char != '0) begin
                    o_q_cmd.op = OP_PUSH;
                end
            end
            C_KIND_POP:   o_q_cmd.op = OP_POP;
            C_KIND_CLEAR: o_q_cmd.op = OP_CLEAR;
            default:      o_q_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_held <= 1'b0;
            r_caps_on    <= 1'b0;
        end else if (accept) begin
            r_shift_held <= n_shift_held;
            r_caps_on    <= n_caps_on;
        end
    end

endmodule

[hdl/scta_queue.sv]
`timescale 1ns / 1ps

module scta_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  scta_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output scta_pkg::t_cmd o_cmd
);
    import scta_pkg::*;

    t_cmd       r_entry [0:1];
    logic       r_wr_idx;
    logic       r_rd_idx;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_entry[r_rd_idx];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_idx] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= 1'b0;
            r_rd_idx <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_idx <= !r_wr_idx;
            end
            if (i_pop) begin
                r_rd_idx <= !r_rd_idx;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[hdl/scta_back.sv]
`timescale 1ns / 1ps

module scta_back #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  scta_pkg::t_cmd                 i_q_cmd,
    output logic                           o_q_pop,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [scta_pkg::C_CHAR_W-1:0]  o_read_char,
    output logic                           o_char_valid,
    output logic                           o_buffer_not_empty,
    output logic                           o_dropped
);
    import scta_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);

    logic [AW-1:0]       r_rd_ptr;
    logic [AW-1:0]       r_wr_ptr;
    logic [AW-1:0]       n_rd_ptr;
    logic [AW-1:0]       n_wr_ptr;
    logic [AW-1:0]       wr_next;
    logic [AW-1:0]       rd_next;
    logic                r_out_valid;
    logic                r_char_valid;
    logic                r_not_empty;
    logic                r_dropped;
    logic                n_char_valid;
    logic                n_dropped;
    logic                advance;
    logic                ram_we;
    logic                ram_re;
    logic [C_CHAR_W-1:0] ram_rdata;

    assign advance = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_q_pop = advance;

    assign wr_next = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
    assign rd_next = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);

    always_comb begin
        n_rd_ptr     = r_rd_ptr;
        n_wr_ptr     = r_wr_ptr;
        n_char_valid = 1'b0;
        n_dropped    = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        if (advance) begin
            unique case (i_q_cmd.op)
                OP_PUSH: begin
                    if (wr_next == r_rd_ptr) begin
                        n_dropped = 1'b1;
                    end else begin
                        ram_we   = 1'b1;
                        n_wr_ptr = wr_next;
                    end
                end
                OP_POP: begin
                    if (r_rd_ptr != r_wr_ptr) begin
                        ram_re       = 1'b1;
                        n_char_valid = 1'b1;
                        n_rd_ptr     = rd_next;
                    end
                end
                OP_CLEAR: begin
                    n_rd_ptr = '0;
                    n_wr_ptr = '0;
                end
                default: begin
                end
            endcase
        end
    end

    scta_ram #(
        .WIDTH (C_CHAR_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_q_cmd.ch),
        .i_re    (ram_re),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr     <= '0;
            r_wr_ptr     <= '0;
            r_out_valid  <= 1'b0;
            r_char_valid <= 1'b0;
            r_not_empty  <= 1'b0;
            r_dropped    <= 1'b0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            if (advance) begin
                r_out_valid  <= 1'b1;
                r_char_valid <= n_char_valid;
                r_not_empty  <= (n_rd_ptr != n_wr_ptr);
                r_dropped    <= n_dropped;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The store's read register only loads on a pop that is moving into the output stage.
    assign o_out_valid        = r_out_valid;
    assign o_read_char        = r_char_valid ? ram_rdata : '0;
    assign o_char_valid       = r_char_valid;
    assign o_buffer_not_empty = r_not_empty;
    assign o_dropped          = r_dropped;

endmodule

[hdl/scancode_to_ascii_fifo.sv]
`timescale 1ns / 1ps

// Set-1 scancode decoder with a US layout and a character ring buffer that holds
// DEPTH-1 characters. Each input transaction is a scancode, a pop or a clear, and
// each one yields exactly one output transaction. The block takes one transaction
// per cycle while the output is not stalled, since each command makes at most one
// access to the character store, which has separate write and read ports. An
// accepted input passes through the command queue and the output register. A
// two-entry command queue separates the decode side from the buffer side, so a
// stalled output still lets two further inputs in. Shift and caps lock state is kept
// across clears; a full buffer drops the character and flags it on that result.
module scancode_to_ascii_fifo #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [scta_pkg::C_KIND_W-1:0]  i_kind,
    input  logic [scta_pkg::C_CODE_W-1:0]  i_scan_code,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [scta_pkg::C_CHAR_W-1:0]  o_read_char,
    output logic                           o_char_valid,
    output logic                           o_buffer_not_empty,
    output logic                           o_dropped
);
    import scta_pkg::*;

    logic q_push;
    logic q_full;
    logic q_valid;
    logic q_pop;
    t_cmd front_cmd;
    t_cmd back_cmd;

    scta_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_scan_code (i_scan_code),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_cmd     (front_cmd)
    );

    scta_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (back_cmd)
    );

    scta_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (q_valid),
        .i_q_cmd            (back_cmd),
        .o_q_pop            (q_pop),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_read_char        (o_read_char),
        .o_char_valid       (o_char_valid),
        .o_buffer_not_empty (o_buffer_not_empty),
        .o_dropped          (o_dropped)
    );

endmodule

[hdl/scta_checker.sv]
`timescale 1ns / 1ps

module scta_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [scta_pkg::C_CHAR_W-1:0]  o_read_char,
    input logic                           o_char_valid,
    input logic                           o_buffer_not_empty,
    input logic                           o_dropped
);

    // Only nonzero characters are ever stored, so a popped character is never zero.
    a_char_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_char_valid |-> o_read_char != '0)
        else $error("popped character is zero");

    a_char_zero_when_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_char_valid |-> o_read_char == '0)
        else $error("character present without a pop");

    a_pop_or_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_char_valid && o_dropped))
        else $error("one transaction both popped and dropped");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_read_char) && $stable(o_char_valid) &&
            $stable(o_buffer_not_empty) && $stable(o_dropped))
        else $error("output transaction changed while stalled");

endmodule

bind scancode_to_ascii_fifo scta_checker u_scta_checker (.*);

[bench/tb_scancode_to_ascii_fifo.sv]
`timescale 1ns / 1ps

module tb_scancode_to_ascii_fifo;
    import scta_pkg::*;

    localparam int unsigned DEPTH       = 16;
    localparam int unsigned RING_AW     = $clog2(DEPTH);
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned HOLD_CYCLES = 200;
    localparam int unsigned MAX_REPORTS = 10;

    localparam logic [C_KIND_W-1:0] KIND_RESERVED = 2'd3;

    localparam logic [C_CHAR_W-1:0] US_PLAIN [0:C_MAP_SIZE-1] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
        7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    localparam logic [C_CHAR_W-1:0] US_SHIFTED [0:C_MAP_SIZE-1] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
        7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    typedef struct packed {
        logic [C_KIND_W-1:0] kind;
        logic [C_CODE_W-1:0] code;
    } key_cmd_t;

    typedef struct packed {
        logic [C_CHAR_W-1:0] ch;
        logic                ch_valid;
        logic                not_empty;
        logic                drop;
    } key_result_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [C_KIND_W-1:0] i_kind = '0;
    logic [C_CODE_W-1:0] i_scan_code = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [C_CHAR_W-1:0] o_read_char;
    logic                o_char_valid;
    logic                o_buffer_not_empty;
    logic                o_dropped;

    key_cmd_t    key_cmd_q[$];
    key_result_t expected_key_results[$];

    logic [C_CHAR_W-1:0] char_ring [DEPTH];
    int unsigned         ring_rd = 0;
    int unsigned         ring_wr = 0;
    bit                  shift_held = 1'b0;
    bit                  caps_on = 1'b0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          recv_hold = 1'b0;
    bit          in_taken = 1'b0;
    event        hold_go;

    int unsigned cycle_cnt = 0;
    int unsigned mismatches = 0;
    int unsigned effective_cmds = 0;
    int unsigned chars_read = 0;
    int unsigned empty_reads = 0;
    int unsigned drops_seen = 0;
    int unsigned clears_sent = 0;

    scancode_to_ascii_fifo #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_kind             (i_kind),
        .i_scan_code        (i_scan_code),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_read_char        (o_read_char),
        .o_char_valid       (o_char_valid),
        .o_buffer_not_empty (o_buffer_not_empty),
        .o_dropped          (o_dropped)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    function automatic key_result_t decode_and_buffer(key_cmd_t c);
        key_result_t r;
        logic [C_CHAR_W-1:0] ch;
        int unsigned nxt;
        r = '0;
        case (c.kind)
            C_KIND_SCAN: begin
                if (c.code == C_LSHIFT_MAKE || c.code == C_RSHIFT_MAKE) begin
                    shift_held = 1'b1;
                end else if (c.code == C_LSHIFT_BREAK || c.code == C_RSHIFT_BREAK) begin
                    shift_held = 1'b0;
                end else if (c.code == C_CAPS_MAKE) begin
                    caps_on = !caps_on;
                end else if (!c.code[7] && c.code < C_MAP_SIZE) begin
                    ch = shift_held ? US_SHIFTED[c.code[5:0]] : US_PLAIN[c.code[5:0]];
                    if (caps_on && ((ch >= 7'h61 && ch <= 7'h7A) ||
                                    (ch >= 7'h41 && ch <= 7'h5A))) begin
                        ch = ch ^ C_CASE_BIT;
                    end
                    if (ch != '0) begin
                        nxt = (ring_wr + 1) % DEPTH;
                        if (nxt == ring_rd) begin
                            r.drop = 1'b1;
                        end else begin
                            char_ring[ring_wr[RING_AW-1:0]] = ch;
                            ring_wr = nxt;
                        end
                    end
                end
            end
            C_KIND_POP: begin
                if (ring_rd != ring_wr) begin
                    r.ch = char_ring[ring_rd[RING_AW-1:0]];
                    r.ch_valid = 1'b1;
                    ring_rd = (ring_rd + 1) % DEPTH;
                end else begin
                    empty_reads++;
                end
            end
            C_KIND_CLEAR: begin
                ring_rd = 0;
                ring_wr = 0;
            end
            default: begin
            end
        endcase
        r.not_empty = (ring_rd != ring_wr);
        return r;
    endfunction

    always @(posedge i_clk) begin : watch_ports
        key_cmd_t    cmd;
        key_result_t want;
        key_result_t got;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                in_taken = 1'b1;
                cmd.kind = i_kind;
                cmd.code = i_scan_code;
                expected_key_results.push_back(decode_and_buffer(cmd));
            end
            if (o_out_valid && i_out_ready) begin
                got.ch = o_read_char;
                got.ch_valid = o_char_valid;
                got.not_empty = o_buffer_not_empty;
                got.drop = o_dropped;
                if (expected_key_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: unexpected result char=%h valid=%b not_empty=%b drop=%b",
                                 $realtime, got.ch, got.ch_valid, got.not_empty, got.drop);
                    end
                end else begin
                    want = expected_key_results.pop_front();
                    if (want.ch_valid) chars_read++;
                    if (want.drop) drops_seen++;
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display({"%0t: mismatch expected char=%h valid=%b not_empty=%b ",
                                      "drop=%b, got char=%h valid=%b not_empty=%b drop=%b"},
                                     $realtime, want.ch, want.ch_valid, want.not_empty,
                                     want.drop, got.ch, got.ch_valid, got.not_empty, got.drop);
                        end
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin : drive_cmds
        key_cmd_t c;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (key_cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                c = key_cmd_q.pop_front();
                i_in_valid <= 1'b1;
                i_kind <= c.kind;
                i_scan_code <= c.code;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    always begin
        @(hold_go);
        recv_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        recv_hold = 1'b0;
    end

    function automatic bit has_effect(key_cmd_t c);
        if (c.kind == KIND_RESERVED) return 1'b0;
        if (c.kind == C_KIND_SCAN && c.code[7] &&
            c.code != C_LSHIFT_BREAK && c.code != C_RSHIFT_BREAK) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void queue_cmd(logic [C_KIND_W-1:0] kind, logic [C_CODE_W-1:0] code);
        key_cmd_t c;
        c.kind = kind;
        c.code = code;
        if (has_effect(c)) effective_cmds++;
        if (kind == C_KIND_CLEAR) clears_sent++;
        key_cmd_q.push_back(c);
    endfunction

    function automatic logic [C_CODE_W-1:0] typing_code();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 66) return C_CODE_W'($urandom_range(C_MAP_SIZE - 1));
        if (r < 74) begin
            case ($urandom_range(3))
                0: return C_LSHIFT_MAKE;
                1: return C_RSHIFT_MAKE;
                2: return C_LSHIFT_BREAK;
                default: return C_RSHIFT_BREAK;
            endcase
        end
        if (r < 78) return C_CAPS_MAKE;
        if (r < 92) return C_CODE_W'(8'h80 | $urandom_range(127));
        return C_CODE_W'($urandom_range(255));
    endfunction

    function automatic void queue_burst();
        int unsigned pick;
        int unsigned len;
        pick = $urandom_range(99);
        len = $urandom_range(1, 20);
        repeat (len) begin
            if (pick < 50) begin
                queue_cmd(C_KIND_SCAN, typing_code());
            end else if (pick < 88) begin
                if ($urandom_range(9) == 0) queue_cmd(C_KIND_SCAN, typing_code());
                else queue_cmd(C_KIND_POP, C_CODE_W'($urandom_range(255)));
            end else begin
                queue_cmd(C_KIND_W'($urandom_range(3)), C_CODE_W'($urandom_range(255)));
            end
        end
    endfunction

    task automatic wait_idle();
        while (key_cmd_q.size() != 0 || i_in_valid || expected_key_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic run_random(int unsigned target);
        while (effective_cmds < target) queue_burst();
        wait_idle();
    endtask

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("Timed out after %0d cycles.", cycle_cnt);
        $display("tb_scancode_to_ascii_fifo: FAIL");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 32;
        recv_idle_pct = 84;

        // Directed walk through shift, caps lock, table limits and ignored codes.
        queue_cmd(C_KIND_POP, 8'h00);
        queue_cmd(KIND_RESERVED, 8'hFF);
        queue_cmd(C_KIND_SCAN, 8'h00);
        queue_cmd(C_KIND_SCAN, 8'h1E);
        queue_cmd(C_KIND_SCAN, 8'h02);
        queue_cmd(C_KIND_SCAN, C_LSHIFT_MAKE);
        queue_cmd(C_KIND_SCAN, 8'h1E);
        queue_cmd(C_KIND_SCAN, 8'h02);
        queue_cmd(C_KIND_SCAN, C_LSHIFT_BREAK);
        queue_cmd(C_KIND_SCAN, C_CAPS_MAKE);
        queue_cmd(C_KIND_SCAN, 8'h10);
        queue_cmd(C_KIND_SCAN, C_RSHIFT_MAKE);
        queue_cmd(C_KIND_SCAN, 8'h10);
        queue_cmd(C_KIND_SCAN, 8'h0C);
        queue_cmd(C_KIND_SCAN, C_RSHIFT_BREAK);
        queue_cmd(C_KIND_SCAN, C_CAPS_MAKE);
        queue_cmd(C_KIND_SCAN, 8'h39);
        queue_cmd(C_KIND_SCAN, 8'h3B);
        queue_cmd(C_KIND_SCAN, 8'hE0);
        queue_cmd(C_KIND_SCAN, 8'h9E);
        queue_cmd(C_KIND_SCAN, 8'hFF);
        queue_cmd(C_KIND_POP, 8'hFF);
        queue_cmd(C_KIND_CLEAR, 8'h00);
        queue_cmd(C_KIND_POP, 8'h00);
        wait_idle();

        run_random(280);

        send_idle_pct = 84;
        recv_idle_pct = 32;
        run_random(550);

        send_idle_pct = 0;
        recv_idle_pct = 0;

        // The output is held off while letters keep coming, which backs up the input
        // side; once the output is released, the letters overflow the buffer.
        -> hold_go;
        repeat (40) queue_cmd(C_KIND_SCAN, C_CODE_W'($urandom_range(8'h10, 8'h19)));
        repeat (20) queue_cmd(C_KIND_POP, C_CODE_W'($urandom_range(255)));
        wait_idle();

        run_random(700);

        repeat (20) @(posedge i_clk);
        if (expected_key_results.size() != 0) mismatches++;
        $display("Ran %0d effective commands over three handshake rate mixes and one long stall.",
                 effective_cmds);
        $display("Read %0d characters, saw %0d empty pops, %0d drops and %0d clears.",
                 chars_read, empty_reads, drops_seen, clears_sent);
        if (mismatches == 0) begin
            $display("tb_scancode_to_ascii_fifo: PASS");
        end else begin
            $display("tb_scancode_to_ascii_fifo: FAIL");
        end
        $finish;
    end

endmodule
